// ----- hdl/mer_pkg.sv -----
// shared types, codes and defaults for the midpoint ellipse raster block
package mer_pkg;

  // default field widths
  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 11;

  // input item kinds, carried on the slave-side tuser
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // quadrant colours
  localparam logic [3:0] COL_PP = 4'd9;   // (+x,+y)
  localparam logic [3:0] COL_MP = 4'd10;  // (-x,+y)
  localparam logic [3:0] COL_MM = 4'd12;  // (-x,-y)
  localparam logic [3:0] COL_PM = 4'd15;  // (+x,-y)

  // which of the four symmetric pixels goes out
  typedef enum logic [1:0] {
    PIX_PP,
    PIX_MP,
    PIX_MM,
    PIX_PM
  } pix_e;

  // operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_A2_RY,
    MUL_A2_B2,
    MUL_B2_X,
    MUL_A2_Y,
    MUL_SQ_X,
    MUL_SQ_Y,
    MUL_B2_P,
    MUL_A2_P
  } mul_sel_e;

  // what to do with the product registered in the previous cycle
  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_A2,
    ACC_B2,
    ACC_DEC_START,
    ACC_AB,
    ACC_P,
    ACC_DEC_SET,
    ACC_ADD4_SUB_AB,
    ACC_ADD8_B2,
    ACC_ADD8,
    ACC_SUB8,
    ACC_SUB8_A2
  } acc_op_e;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_RX,
    S_SQ_RY,
    S_A2RY,
    S_A2B2,
    S_AB,
    S_CHK_X,
    S_CHK_Y,
    S_CHK,
    S_R2_SX,
    S_R2_BX,
    S_R2_SY,
    S_R2_AY,
    S_R2_FIN,
    S_MX1,
    S_AX1,
    S_MX2,
    S_MY,
    S_MY0,
    S_AY,
    S_E0,
    S_E1,
    S_E2,
    S_E3
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_start;
    logic     step_x;
    logic     step_y;
    logic     set_region2;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     out_load;
    pix_e     pix_idx;
    logic     busy_upd;
  } mer_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic busy;
    logic region2;
    logic dec_pos;
    logic r1_holds;
    logic out_free;
  } mer_status_t;

endpackage

// ----- hdl/midpoint_ellipse_raster.sv -----
// top level of the midpoint ellipse pixel generator
//
// channel  direction  tdata                                       tlast         tuser
// s_axis   in         center_x, center_y, radius_x, radius_y      -             cmd
// m_axis   out        pixel_x, pixel_y, colour                    last_of_step  done_res
//
// a start item squares the radii and checks the region, plus region-2 setup on a switch;
// an advance item steps x, y or both and the decision, plus region-2 setup at the switch
// the time taken is set by the one shared multiplier, which does one product per cycle,
// and by the four pixels leaving one per cycle when not stalled, via the output register
// reset clears the controller, the busy and region flags and the output valid
// a stalled output holds the pixel beat; the next item is taken while the last pixel waits
module midpoint_ellipse_raster import mer_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int IN_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
  parameter int OUT_W = ((2 * (COORD_BITS + 2) + 4 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // center_x, center_y, radius_x, radius_y, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  // cmd
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // pixel_x, pixel_y, colour, zero fill
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast,
  // done_res
  output logic             m_axis_tuser
);

  localparam int PW = COORD_BITS + 2;

  mer_cmd_t    cmd;
  mer_status_t status;
  logic [PW-1:0] pixel_x, pixel_y;
  logic [3:0]    colour;

  // controller
  mer_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath
  mer_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .center_x_i (s_axis_tdata[COORD_BITS-1:0]),
    .center_y_i (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius_x_i (s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .radius_y_i (s_axis_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS]),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .pixel_x_o  (pixel_x),
    .pixel_y_o  (pixel_y),
    .colour_o   (colour),
    .last_o     (m_axis_tlast),
    .done_o     (m_axis_tuser)
  );

  // output packing
  assign m_axis_tdata = OUT_W'({colour, pixel_y, pixel_x});

  // a done pixel always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("done pixel without last flag");

  // the closing pixel of a run is the (+x,-y) quadrant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> colour == COL_PM)
    else $error("last pixel has wrong quadrant colour");

  // a start item occupies the block on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_START) |=> !s_axis_tready)
    else $error("input still ready right after a start item");

  // an advance while idle is dropped and leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_ADVANCE) && !status.busy
    |=> s_axis_tready)
    else $error("advance while idle was not ignored");

endmodule

// ----- hdl/mer_ctrl.sv -----
// controller state machine sequencing the shared multiplier and pixel beats
module mer_ctrl import mer_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_kind_i,
  output logic        s_ready_o,
  input  mer_status_t status_i,
  output mer_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        is_start;
  logic        do_x;
  logic        do_y;

  // step direction for an advance item
  assign is_start = (s_kind_i == CMD_START);
  assign do_x     = !status_i.region2 || !status_i.dec_pos;
  assign do_y     = status_i.region2 || status_i.dec_pos;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          if (is_start) begin
            state_d = S_SQ_RX;
          end else if (status_i.busy) begin
            if (do_x && do_y) begin
              state_d = S_MX2;
            end else if (do_x) begin
              state_d = S_MX1;
            end else begin
              state_d = S_MY0;
            end
          end
        end
      end
      S_SQ_RX:  state_d = S_SQ_RY;
      S_SQ_RY:  state_d = S_A2RY;
      S_A2RY:   state_d = S_A2B2;
      S_A2B2:   state_d = S_AB;
      S_AB:     state_d = S_CHK_X;
      S_CHK_X:  state_d = S_CHK_Y;
      S_CHK_Y:  state_d = S_CHK;
      S_CHK: begin
        if (status_i.r1_holds) begin
          state_d = S_E0;
        end else begin
          state_d = S_R2_SX;
        end
      end
      S_R2_SX:  state_d = S_R2_BX;
      S_R2_BX:  state_d = S_R2_SY;
      S_R2_SY:  state_d = S_R2_AY;
      S_R2_AY:  state_d = S_R2_FIN;
      S_R2_FIN: state_d = S_E0;
      S_MX1:    state_d = S_AX1;
      S_AX1:    state_d = S_CHK_X;
      S_MX2:    state_d = S_MY;
      S_MY:     state_d = S_AY;
      S_MY0:    state_d = S_AY;
      S_AY: begin
        if (status_i.region2) begin
          state_d = S_E0;
        end else begin
          state_d = S_CHK_X;
        end
      end
      S_E0: begin
        if (status_i.out_free) state_d = S_E1;
      end
      S_E1: begin
        if (status_i.out_free) state_d = S_E2;
      end
      S_E2: begin
        if (status_i.out_free) state_d = S_E3;
      end
      S_E3: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    s_ready_o         = 1'b0;
    cmd_o.load_start  = 1'b0;
    cmd_o.step_x      = 1'b0;
    cmd_o.step_y      = 1'b0;
    cmd_o.set_region2 = 1'b0;
    cmd_o.mul_sel     = MUL_RX_RX;
    cmd_o.acc_op      = ACC_NONE;
    cmd_o.out_load    = 1'b0;
    cmd_o.pix_idx     = PIX_PP;
    cmd_o.busy_upd    = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i && is_start) begin
          cmd_o.load_start = 1'b1;
        end else if (s_valid_i && status_i.busy) begin
          cmd_o.step_x = do_x;
          cmd_o.step_y = do_y;
        end
      end
      S_SQ_RX: cmd_o.mul_sel = MUL_RX_RX;
      S_SQ_RY: begin
        cmd_o.mul_sel = MUL_RY_RY;
        cmd_o.acc_op  = ACC_A2;
      end
      S_A2RY: begin
        cmd_o.mul_sel = MUL_A2_RY;
        cmd_o.acc_op  = ACC_B2;
      end
      S_A2B2: begin
        cmd_o.mul_sel = MUL_A2_B2;
        cmd_o.acc_op  = ACC_DEC_START;
      end
      S_AB:    cmd_o.acc_op = ACC_AB;
      S_CHK_X: cmd_o.mul_sel = MUL_B2_X;
      S_CHK_Y: begin
        cmd_o.mul_sel = MUL_A2_Y;
        cmd_o.acc_op  = ACC_P;
      end
      S_CHK:   cmd_o.set_region2 = !status_i.r1_holds;
      S_R2_SX: cmd_o.mul_sel = MUL_SQ_X;
      S_R2_BX: cmd_o.mul_sel = MUL_B2_P;
      S_R2_SY: begin
        cmd_o.mul_sel = MUL_SQ_Y;
        cmd_o.acc_op  = ACC_DEC_SET;
      end
      S_R2_AY:  cmd_o.mul_sel = MUL_A2_P;
      S_R2_FIN: cmd_o.acc_op = ACC_ADD4_SUB_AB;
      S_MX1:    cmd_o.mul_sel = MUL_B2_X;
      S_AX1:    cmd_o.acc_op = ACC_ADD8_B2;
      S_MX2:    cmd_o.mul_sel = MUL_B2_X;
      S_MY: begin
        cmd_o.mul_sel = MUL_A2_Y;
        cmd_o.acc_op  = status_i.region2 ? ACC_ADD8 : ACC_ADD8_B2;
      end
      S_MY0:    cmd_o.mul_sel = MUL_A2_Y;
      S_AY:     cmd_o.acc_op = status_i.region2 ? ACC_SUB8_A2 : ACC_SUB8;
      S_E0: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.pix_idx  = PIX_PP;
      end
      S_E1: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.pix_idx  = PIX_MP;
      end
      S_E2: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.pix_idx  = PIX_MM;
      end
      S_E3: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.pix_idx  = PIX_PM;
        cmd_o.busy_upd = status_i.out_free;
      end
      default: s_ready_o = 1'b0;
    endcase
  end

endmodule

// ----- hdl/mer_datapath.sv -----
// datapath: held geometry, shared multiplier, decision accumulator, pixel output register
module mer_datapath import mer_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [COORD_BITS-1:0]   center_x_i,
  input  logic [COORD_BITS-1:0]   center_y_i,
  input  logic [RADIUS_BITS-1:0]  radius_x_i,
  input  logic [RADIUS_BITS-1:0]  radius_y_i,
  input  mer_cmd_t                cmd_i,
  output mer_status_t             status_o,
  input  logic                    m_ready_i,
  output logic                    m_valid_o,
  output logic [COORD_BITS+1:0]   pixel_x_o,
  output logic [COORD_BITS+1:0]   pixel_y_o,
  output logic [3:0]              colour_o,
  output logic                    last_o,
  output logic                    done_o
);

  localparam int OUT_W = COORD_BITS + 2;
  localparam int AW    = 2 * RADIUS_BITS;
  localparam int OPW   = ((AW > 2 * COORD_BITS + 2) ? AW : 2 * COORD_BITS + 2) + 1;
  localparam int DW    = 2 * RADIUS_BITS + 2 * COORD_BITS + 5;

  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic [RADIUS_BITS-1:0] rx_q, ry_q;
  logic [AW-1:0]          a2_q, a2_d, b2_q, b2_d;
  logic signed [DW-1:0]   ab_q, ab_d, p_q, p_d, prod_q, prod_d, dec_q, dec_d;
  logic [COORD_BITS-1:0]  x_q, x_d, y_q, y_d;
  logic                   region2_q, region2_d, busy_q, busy_d, m_valid_q, m_valid_d;

  logic signed [OPW-1:0]   op_a, op_b;
  logic signed [2*OPW-1:0] mul_full;
  logic signed [DW-1:0]    a2_ext, b2_ext;

  logic [OUT_W-1:0] cx_e, cy_e, x_e, y_e;
  logic [OUT_W-1:0] px_d, py_d, px_q, py_q;
  logic [3:0]       col_d, col_q;
  logic             last_d, last_q, done_d, done_q;
  logic             out_free;

  // multiplier operand selection
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RX_RX: begin
        op_a = OPW'(rx_q);
        op_b = OPW'(rx_q);
      end
      MUL_RY_RY: begin
        op_a = OPW'(ry_q);
        op_b = OPW'(ry_q);
      end
      MUL_A2_RY: begin
        op_a = OPW'(a2_q);
        op_b = OPW'(ry_q);
      end
      MUL_A2_B2: begin
        op_a = OPW'(a2_q);
        op_b = OPW'(b2_q);
      end
      MUL_B2_X: begin
        op_a = OPW'(b2_q);
        op_b = OPW'(x_q);
      end
      MUL_A2_Y: begin
        op_a = OPW'(a2_q);
        op_b = OPW'(y_q);
      end
      MUL_SQ_X: begin
        op_a = OPW'({x_q, 1'b1});
        op_b = OPW'({x_q, 1'b1});
      end
      MUL_SQ_Y: begin
        // y - 1, may be minus one on the final row
        op_a = OPW'(y_q) + {OPW{1'b1}};
        op_b = OPW'(y_q) + {OPW{1'b1}};
      end
      MUL_B2_P: begin
        op_a = OPW'(b2_q);
        op_b = prod_q[OPW-1:0];
      end
      MUL_A2_P: begin
        op_a = OPW'(a2_q);
        op_b = prod_q[OPW-1:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // shared multiplier, registered
  assign mul_full = op_a * op_b;
  assign prod_d   = mul_full[DW-1:0];

  assign a2_ext = DW'(a2_q);
  assign b2_ext = DW'(b2_q);

  // accumulate and store products
  always_comb begin
    a2_d  = a2_q;
    b2_d  = b2_q;
    ab_d  = ab_q;
    p_d   = p_q;
    dec_d = dec_q;
    case (cmd_i.acc_op)
      ACC_NONE:        dec_d = dec_q;
      ACC_A2:          a2_d  = prod_q[AW-1:0];
      ACC_B2:          b2_d  = prod_q[AW-1:0];
      ACC_DEC_START:   dec_d = (b2_ext <<< 2) - (prod_q <<< 2) + a2_ext;
      ACC_AB:          ab_d  = prod_q;
      ACC_P:           p_d   = prod_q;
      ACC_DEC_SET:     dec_d = prod_q;
      ACC_ADD4_SUB_AB: dec_d = dec_q + (prod_q <<< 2) - (ab_q <<< 2);
      ACC_ADD8_B2:     dec_d = dec_q + (prod_q <<< 3) + (b2_ext <<< 2);
      ACC_ADD8:        dec_d = dec_q + (prod_q <<< 3);
      ACC_SUB8:        dec_d = dec_q - (prod_q <<< 3);
      ACC_SUB8_A2:     dec_d = dec_q - (prod_q <<< 3) + (a2_ext <<< 2);
      default:         dec_d = dec_q;
    endcase
  end

  // current point
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (cmd_i.load_start) begin
      x_d = '0;
      y_d = COORD_BITS'(radius_y_i);
    end else begin
      if (cmd_i.step_x) x_d = x_q + COORD_BITS'(1);
      if (cmd_i.step_y) y_d = y_q - COORD_BITS'(1);
    end
  end

  // region and busy flags
  always_comb begin
    region2_d = region2_q;
    busy_d    = busy_q;
    if (cmd_i.load_start) begin
      region2_d = 1'b0;
    end else if (cmd_i.set_region2) begin
      region2_d = 1'b1;
    end
    if (cmd_i.busy_upd) busy_d = (y_q != '0);
  end

  // symmetric pixel for the current beat
  assign cx_e = OUT_W'(cx_q);
  assign cy_e = OUT_W'(cy_q);
  assign x_e  = OUT_W'(x_q);
  assign y_e  = OUT_W'(y_q);

  always_comb begin
    last_d = 1'b0;
    done_d = 1'b0;
    case (cmd_i.pix_idx)
      PIX_PP: begin
        px_d  = cx_e + x_e;
        py_d  = cy_e + y_e;
        col_d = COL_PP;
      end
      PIX_MP: begin
        px_d  = cx_e - x_e;
        py_d  = cy_e + y_e;
        col_d = COL_MP;
      end
      PIX_MM: begin
        px_d  = cx_e - x_e;
        py_d  = cy_e - y_e;
        col_d = COL_MM;
      end
      PIX_PM: begin
        px_d   = cx_e + x_e;
        py_d   = cy_e - y_e;
        col_d  = COL_PM;
        last_d = 1'b1;
        done_d = (y_q == '0);
      end
      default: begin
        px_d  = cx_e;
        py_d  = cy_e;
        col_d = COL_PP;
      end
    endcase
  end

  // output register handshake
  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region2_q <= 1'b0;
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      region2_q <= region2_d;
      busy_q    <= busy_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      rx_q <= radius_x_i;
      ry_q <= radius_y_i;
    end
    prod_q <= prod_d;
    a2_q   <= a2_d;
    b2_q   <= b2_d;
    ab_q   <= ab_d;
    p_q    <= p_d;
    dec_q  <= dec_d;
    x_q    <= x_d;
    y_q    <= y_d;
    if (cmd_i.out_load) begin
      px_q   <= px_d;
      py_q   <= py_d;
      col_q  <= col_d;
      last_q <= last_d;
      done_q <= done_d;
    end
  end

  // status back to the controller
  assign status_o.busy     = busy_q;
  assign status_o.region2  = region2_q;
  assign status_o.dec_pos  = !dec_q[DW-1] && (dec_q != '0);
  assign status_o.r1_holds = (p_q < prod_q);
  assign status_o.out_free = out_free;

  assign m_valid_o = m_valid_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;
  assign colour_o  = col_q;
  assign last_o    = last_q;
  assign done_o    = done_q;

endmodule

// ----- test/midpoint_ellipse_raster_tb.sv -----
// testbench for the midpoint ellipse raster block: random streams checked by a cycle-free predictor
`timescale 1ns / 1ps

module midpoint_ellipse_raster_tb;
  import mer_pkg::*;

  localparam int CW            = COORD_BITS_DEF;
  localparam int RW            = RADIUS_BITS_DEF;
  localparam int PW            = CW + 2;
  localparam int IN_W          = ((2 * CW + 2 * RW + 7) / 8) * 8;
  localparam int OUT_W         = ((2 * PW + 4 + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 480;

  // one input item as queued for the driver
  typedef struct {
    logic          cmd;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
    bit            drain;
  } ellipse_cmd_t;

  // one pixel as it should leave the block
  typedef struct {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [3:0]    colour;
    logic          last;
    logic          done;
  } pixel_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // center_x, center_y, radius_x, radius_y, zero fill
  logic [IN_W-1:0]  s_axis_tdata = '0;
  // cmd
  logic             s_axis_tuser = CMD_START;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // pixel_x, pixel_y, colour
  logic [OUT_W-1:0] m_axis_tdata;
  // last_of_step
  logic             m_axis_tlast;
  // done_res
  logic             m_axis_tuser;

  ellipse_cmd_t stim_q[$];
  pixel_t       pending_pixels[$];

  int items_sent    = 0;
  int items_taken   = 0;
  int pixels_seen   = 0;
  int pixels_acked  = 0;
  int send_gap      = 0;
  int send_quiet    = 0;
  int recv_gap      = 0;
  int recv_quiet    = 0;
  int idle_cycles   = 0;
  int errors        = 0;

  // predictor state
  longint        pos_x = 0;
  longint        pos_y = 0;
  longint        dec_val = 0;
  longint        rad_a = 0;
  longint        rad_b = 0;
  bit            region_two = 1'b0;
  bit            tracing = 1'b0;
  logic [CW-1:0] org_x = '0;
  logic [CW-1:0] org_y = '0;

  midpoint_ellipse_raster dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // wait cycles per item, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic pixel_t make_pixel(longint px, longint py, logic [3:0] colour,
                                        logic last, logic done);
    pixel_t p;
    p.px     = px[PW-1:0];
    p.py     = py[PW-1:0];
    p.colour = colour;
    p.last   = last;
    p.done   = done;
    return p;
  endfunction

  // four symmetric pixels of the current point
  task automatic push_four(bit done);
    longint cx;
    longint cy;
    cx = org_x;
    cy = org_y;
    pending_pixels.push_back(make_pixel(cx + pos_x, cy + pos_y, COL_PP, 1'b0, 1'b0));
    pending_pixels.push_back(make_pixel(cx - pos_x, cy + pos_y, COL_MP, 1'b0, 1'b0));
    pending_pixels.push_back(make_pixel(cx - pos_x, cy - pos_y, COL_MM, 1'b0, 1'b0));
    pending_pixels.push_back(make_pixel(cx + pos_x, cy - pos_y, COL_PM, 1'b1, done));
  endtask

  // leave region 1 once ry^2*x < rx^2*y fails, reloading the decision value
  task automatic switch_region_if_due();
    longint a2;
    longint b2;
    a2 = rad_a * rad_a;
    b2 = rad_b * rad_b;
    if (!region_two && !(b2 * pos_x < a2 * pos_y)) begin
      region_two = 1'b1;
      dec_val = b2 * (2 * pos_x + 1) * (2 * pos_x + 1)
              + 4 * a2 * (pos_y - 1) * (pos_y - 1)
              - 4 * a2 * b2;
    end
  endtask

  // midpoint step of the ellipse, decision kept scaled by 4
  task automatic trace_item(logic cmd, logic [CW-1:0] cx, logic [CW-1:0] cy,
                            logic [RW-1:0] rx, logic [RW-1:0] ry);
    longint a2;
    longint b2;
    bit     done;
    if (cmd == CMD_START) begin
      org_x      = cx;
      org_y      = cy;
      rad_a      = rx;
      rad_b      = ry;
      a2         = rad_a * rad_a;
      b2         = rad_b * rad_b;
      pos_x      = 0;
      pos_y      = rad_b;
      dec_val    = 4 * b2 - 4 * a2 * rad_b + a2;
      region_two = 1'b0;
      switch_region_if_due();
      done    = (pos_y == 0);
      tracing = !done;
      push_four(done);
    end else if (tracing) begin
      a2 = rad_a * rad_a;
      b2 = rad_b * rad_b;
      if (!region_two) begin
        pos_x++;
        if (dec_val <= 0) begin
          dec_val += 8 * b2 * pos_x + 4 * b2;
        end else begin
          pos_y--;
          dec_val += 8 * b2 * pos_x - 8 * a2 * pos_y + 4 * b2;
        end
        switch_region_if_due();
      end else if (dec_val <= 0) begin
        pos_x++;
        pos_y--;
        dec_val += 8 * b2 * pos_x - 8 * a2 * pos_y + 4 * a2;
      end else begin
        pos_y--;
        dec_val += 4 * a2 - 8 * a2 * pos_y;
      end
      done = (pos_y == 0);
      if (done) tracing = 1'b0;
      push_four(done);
    end
  endtask

  task automatic add_cmd(logic cmd, int cx, int cy, int rx, int ry, bit drain);
    ellipse_cmd_t c;
    c.cmd   = cmd;
    c.cx    = cx[CW-1:0];
    c.cy    = cy[CW-1:0];
    c.rx    = rx[RW-1:0];
    c.ry    = ry[RW-1:0];
    c.drain = drain;
    stim_q.push_back(c);
  endtask

  // advance items carry junk in the data fields, which must be ignored
  task automatic add_advances(int n);
    for (int i = 0; i < n; i++) begin
      add_cmd(CMD_ADVANCE, $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 2047), $urandom_range(0, 2047), 1'b0);
    end
  endtask

  // predict on every accepted input item
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      trace_item(s_axis_tuser, s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW],
                 s_axis_tdata[2*CW+RW-1:2*CW], s_axis_tdata[2*CW+2*RW-1:2*CW+RW]);
      items_taken++;
    end
  end

  // driver: present queued items with random gaps
  always @(negedge clk_i) begin
    ellipse_cmd_t nxt;
    logic         nxt_valid;
    nxt_valid = s_axis_tvalid;
    if (rst_ni && (!s_axis_tvalid || items_taken == items_sent)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (stim_q.size() > 0 && !(stim_q[0].drain && pending_pixels.size() != 0)) begin
        nxt = stim_q.pop_front();
        s_axis_tdata <= {{(IN_W - 2 * CW - 2 * RW){1'b0}}, nxt.ry, nxt.rx, nxt.cy, nxt.cx};
        s_axis_tuser <= nxt.cmd;
        nxt_valid = 1'b1;
        items_sent++;
        send_gap = draw_gap(send_quiet);
      end
    end
    s_axis_tvalid <= nxt_valid;
  end

  // monitor: compare each pixel with the oldest prediction
  always @(posedge clk_i) begin
    pixel_t exp_pix;
    if (m_axis_tvalid && m_axis_tready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", $signed(m_axis_tdata[PW-1:0]),
               $signed(m_axis_tdata[2*PW-1:PW]));
        errors++;
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (m_axis_tdata[PW-1:0] !== exp_pix.px) begin
          $error("pixel_x expected %0d got %0d", $signed(exp_pix.px),
                 $signed(m_axis_tdata[PW-1:0]));
          errors++;
        end
        if (m_axis_tdata[2*PW-1:PW] !== exp_pix.py) begin
          $error("pixel_y expected %0d got %0d", $signed(exp_pix.py),
                 $signed(m_axis_tdata[2*PW-1:PW]));
          errors++;
        end
        if (m_axis_tdata[2*PW+3:2*PW] !== exp_pix.colour) begin
          $error("colour expected %0d got %0d", exp_pix.colour, m_axis_tdata[2*PW+3:2*PW]);
          errors++;
        end
        if (m_axis_tlast !== exp_pix.last) begin
          $error("last_of_step expected %0b got %0b", exp_pix.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== exp_pix.done) begin
          $error("done_res expected %0b got %0b", exp_pix.done, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // receiver stalls: ready may drop for a random count after each pixel
  always @(negedge clk_i) begin
    logic rdy;
    rdy = m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tready && pixels_seen != pixels_acked) begin
        pixels_acked = pixels_seen;
        recv_gap = draw_gap(recv_quiet);
        rdy = (recv_gap == 0);
      end else if (!m_axis_tready) begin
        if (recv_gap > 0) recv_gap--;
        rdy = (recv_gap == 0);
      end
    end
    m_axis_tready <= rdy;
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int  rx;
    int  ry;
    int  steps;
    bit  big_x;
    bit  big_y;
    bit  first;

    // directed: idle advances, degenerate radii, extremes, restart while busy
    add_advances(1);
    add_cmd(CMD_START, 100, 200, 5, 0, 1'b0);
    add_advances(1);
    add_cmd(CMD_START, 0, 0, 0, 0, 1'b0);
    add_cmd(CMD_START, 2048, 1024, 0, 3, 1'b0);
    add_advances(3);
    add_cmd(CMD_START, 0, 0, 3, 2, 1'b0);
    add_advances(6);
    add_cmd(CMD_START, 4095, 4095, 2047, 2047, 1'b0);
    add_advances(2);
    add_cmd(CMD_START, 7, 9, 1, 1, 1'b0);
    add_advances(2);
    add_cmd(CMD_START, 4095, 0, 2047, 1, 1'b0);
    add_advances(2);

    // random ellipses, mostly small and run to the end, some abandoned
    first = 1'b1;
    while (stim_q.size() < RANDOM_ITEMS + 24) begin
      big_x = ($urandom_range(0, 5) == 0);
      big_y = ($urandom_range(0, 5) == 0);
      rx = big_x ? $urandom_range(0, 2047) : $urandom_range(0, 12);
      ry = big_y ? $urandom_range(0, 2047) : $urandom_range(0, 12);
      if (big_x || big_y) begin
        steps = $urandom_range(0, 16);
      end else begin
        steps = rx + ry + 1;
        if ($urandom_range(0, 3) == 0) steps = $urandom_range(0, steps);
      end
      add_cmd(CMD_START, $urandom_range(0, 4095), $urandom_range(0, 4095), rx, ry,
              first || ($urandom_range(0, 24) == 0));
      first = 1'b0;
      add_advances(steps);
      if ($urandom_range(0, 7) == 0) add_advances($urandom_range(1, 3));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_q.size() != 0 || items_taken != items_sent || pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
